FILE: hw/rtl/clup_pkg.sv
// ----------------------------------------------------------------------------
// Cache line utilization profiler package
// Shared constants, item kinds, command and result records.
// ----------------------------------------------------------------------------
package clup_pkg;

	localparam int unsigned MAX_LINES = 8192;
	localparam int unsigned LINE_AW   = $clog2(MAX_LINES);
	localparam int unsigned LAST_LINE = MAX_LINES - 1;

	localparam logic [3:0] SHIFT_MIN = 4'd3;
	localparam logic [3:0] SHIFT_MAX = 4'd8;
	localparam logic [3:0] SHIFT_DEF = 4'd6;

	typedef logic [LINE_AW-1:0] line_t;
	typedef logic [LINE_AW+8:0] baddr_t;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_SUM   = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  shift;
		logic [15:0] off;
		logic [17:0] end_b;
		line_t       first;
		line_t       stop;
		logic        has_lines;
		logic        split;
		logic [12:0] idx;
		logic        idx_ok;
	} cmd_t;

	typedef struct packed {
		logic [12:0] line_number;
		logic [15:0] line_byte_offset;
		logic [8:0]  used_bytes;
		logic [8:0]  spare_bytes;
		logic        line_split;
		logic        line_active;
		logic [13:0] arena_lines;
		logic [13:0] live_lines;
		logic [13:0] full_lines;
		logic [15:0] split_blocks;
		logic [16:0] used_byte_sum;
		logic        block_was_split;
	} res_t;

	function automatic logic [3:0] eff_shift(input logic [3:0] s);
		if (s < SHIFT_MIN || s > SHIFT_MAX) begin
			return SHIFT_DEF;
		end
		return s;
	endfunction

endpackage

FILE: hw/rtl/clup_front.sv
// ----------------------------------------------------------------------------
// Profiler front end
// Accepts items, decodes the line span of a block and queues commands.
// ----------------------------------------------------------------------------
module clup_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         kind,
	input  logic [15:0]        block_offset,
	input  logic [16:0]        block_size,
	input  logic [12:0]        line_sel,
	input  logic [3:0]         line_shift,
	input  logic               hold,
	output logic               cmd_valid,
	output clup_pkg::cmd_t     cmd,
	input  logic               cmd_take
);

	clup_pkg::cmd_t dec;
	clup_pkg::cmd_t q_mem [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic [3:0]     eff;
	logic [17:0]    end_b;
	logic [14:0]    first_w;
	logic [14:0]    last_w;
	logic           nonzero;
	logic           do_push;

	always_comb begin
		eff     = clup_pkg::eff_shift(line_shift);
		end_b   = 18'(block_offset) + 18'(block_size);
		first_w = 15'(block_offset >> eff);
		last_w  = 15'((end_b - 18'd1) >> eff);
		nonzero = block_size != 17'd0;
		dec.kind      = clup_pkg::kind_t'(kind);
		dec.shift     = eff;
		dec.off       = block_offset;
		dec.end_b     = end_b;
		dec.first     = clup_pkg::line_t'(first_w);
		dec.stop      = (32'(last_w) > clup_pkg::LAST_LINE) ?
			clup_pkg::line_t'(clup_pkg::LAST_LINE) : clup_pkg::line_t'(last_w);
		dec.has_lines = nonzero && (32'(first_w) < clup_pkg::MAX_LINES);
		dec.split     = nonzero && (last_w > first_w);
		dec.idx       = line_sel;
		dec.idx_ok    = 32'(line_sel) < clup_pkg::MAX_LINES;
	end

	assign full      = (cnt_q == 2'd2) || hold;
	assign do_push   = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_take && cmd_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(cmd_take && cmd_valid);
		end
	end

endmodule

FILE: hw/rtl/clup_res_q.sv
// ----------------------------------------------------------------------------
// Profiler result queue
// Two-entry queue that holds finished results until they are popped.
// ----------------------------------------------------------------------------
module clup_res_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  clup_pkg::res_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output clup_pkg::res_t head
);

	clup_pkg::res_t q_mem [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = q_mem[rd_ptr_q];
	assign do_wr = wr && !full;
	assign do_rd = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			q_mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule

FILE: hw/rtl/clup_back.sv
// ----------------------------------------------------------------------------
// Profiler back end
// Executes queued commands against the line table and running counters.
// ----------------------------------------------------------------------------
module clup_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  clup_pkg::cmd_t     cmd,
	output logic               cmd_take,
	input  logic [16:0]        arena_bytes,
	output logic               init_busy,
	output logic               res_wr,
	output clup_pkg::res_t     res,
	input  logic               res_full
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_RD   = 5'b00010,
		B_UPD  = 5'b00100,
		B_CLR  = 5'b01000,
		B_OUT  = 5'b10000
	} bstate_t;

	bstate_t          state_q;
	clup_pkg::cmd_t   cur_q;
	clup_pkg::line_t  line_q;
	logic             clr_emit_q;
	clup_pkg::res_t   res_q;
	logic [13:0]      active_q;
	logic [13:0]      full_cnt_q;
	logic [15:0]      split_q;
	logic [16:0]      sum_q;

	logic [9:0]       mem [clup_pkg::MAX_LINES];
	logic [9:0]       rd_q;
	logic             we;
	logic [9:0]       wdata;
	clup_pkg::line_t  raddr;

	logic [8:0]       lsz;
	logic [8:0]       old;
	clup_pkg::baddr_t ls;
	clup_pkg::baddr_t le;
	clup_pkg::baddr_t os;
	clup_pkg::baddr_t oe;
	logic [8:0]       ov;
	logic [9:0]       sum10;
	logic [8:0]       nw;
	logic             upd_bytes;
	logic [17:0]      sum18;
	logic [8:0]       used;
	logic [8:0]       c_lsz;
	logic [17:0]      tot18;
	logic [17:0]      tot_sh;

	assign init_busy = (state_q == B_CLR) && !clr_emit_q;
	assign cmd_take  = (state_q == B_IDLE) && cmd_valid;
	assign res_wr    = (state_q == B_OUT);
	assign res       = res_q;
	assign raddr     = line_q;

	always_comb begin
		lsz       = 9'd1 << cur_q.shift;
		old       = rd_q[8:0];
		ls        = clup_pkg::baddr_t'(line_q) << cur_q.shift;
		le        = ls + clup_pkg::baddr_t'(lsz);
		os        = (clup_pkg::baddr_t'(cur_q.off) > ls) ? clup_pkg::baddr_t'(cur_q.off) : ls;
		oe        = (clup_pkg::baddr_t'(cur_q.end_b) < le) ?
			clup_pkg::baddr_t'(cur_q.end_b) : le;
		ov        = 9'(oe - os);
		sum10     = 10'(old) + 10'(ov);
		nw        = (sum10 > 10'(lsz)) ? lsz : sum10[8:0];
		upd_bytes = old < lsz;
		sum18     = 18'(sum_q) + 18'(nw - old);
		used      = (old > lsz) ? lsz : old;
		we        = 1'b0;
		wdata     = 10'd0;
		if (state_q == B_CLR) begin
			we = 1'b1;
		end else if (state_q == B_UPD && cur_q.kind == clup_pkg::KIND_ADD) begin
			we    = 1'b1;
			wdata = {rd_q[9] | cur_q.split, upd_bytes ? nw : old};
		end
		c_lsz  = 9'd1 << cmd.shift;
		tot18  = 18'(arena_bytes) + 18'(c_lsz) - 18'd1;
		tot_sh = tot18 >> cmd.shift;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[line_q] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cur_q <= cmd;
					res_q <= '0;
					if (cmd.kind == clup_pkg::KIND_ADD) begin
						res_q.block_was_split <= cmd.split;
					end
					if (cmd.kind == clup_pkg::KIND_READ) begin
						res_q.line_number      <= cmd.idx;
						res_q.line_byte_offset <= 16'(21'(cmd.idx) << cmd.shift);
						res_q.spare_bytes      <= c_lsz;
					end
					if (cmd.kind == clup_pkg::KIND_SUM && arena_bytes != 17'd0) begin
						res_q.arena_lines   <= (tot_sh > 18'd16383) ? 14'd16383 : tot_sh[13:0];
						res_q.live_lines    <= active_q;
						res_q.full_lines    <= full_cnt_q;
						res_q.split_blocks  <= split_q;
						res_q.used_byte_sum <= sum_q;
					end
				end
			end
			B_UPD: begin
				if (cur_q.kind == clup_pkg::KIND_READ) begin
					res_q.used_bytes  <= used;
					res_q.spare_bytes <= lsz - used;
					res_q.line_split  <= rd_q[9];
					res_q.line_active <= used != 9'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLR;
			line_q     <= '0;
			clr_emit_q <= 1'b0;
			active_q   <= '0;
			full_cnt_q <= '0;
			split_q    <= '0;
			sum_q      <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							clup_pkg::KIND_ADD: begin
								if (cmd.split && split_q != 16'hFFFF) begin
									split_q <= split_q + 16'd1;
								end
								line_q  <= cmd.first;
								state_q <= cmd.has_lines ? B_RD : B_OUT;
							end
							clup_pkg::KIND_READ: begin
								line_q  <= clup_pkg::line_t'(cmd.idx);
								state_q <= cmd.idx_ok ? B_RD : B_OUT;
							end
							clup_pkg::KIND_CLEAR: begin
								line_q     <= '0;
								clr_emit_q <= 1'b1;
								active_q   <= '0;
								full_cnt_q <= '0;
								split_q    <= '0;
								sum_q      <= '0;
								state_q    <= B_CLR;
							end
							default: begin
								state_q <= B_OUT;
							end
						endcase
					end
				end
				B_RD: begin
					state_q <= B_UPD;
				end
				B_UPD: begin
					if (cur_q.kind == clup_pkg::KIND_ADD) begin
						if (upd_bytes) begin
							if (old == 9'd0 && active_q != 14'h3FFF) begin
								active_q <= active_q + 14'd1;
							end
							if (nw == lsz && full_cnt_q != 14'h3FFF) begin
								full_cnt_q <= full_cnt_q + 14'd1;
							end
							sum_q <= (sum18 > 18'h1FFFF) ? 17'h1FFFF : sum18[16:0];
						end
						if (line_q == cur_q.stop) begin
							state_q <= B_OUT;
						end else begin
							line_q  <= line_q + clup_pkg::line_t'(1);
							state_q <= B_RD;
						end
					end else begin
						state_q <= B_OUT;
					end
				end
				B_CLR: begin
					if (32'(line_q) == clup_pkg::LAST_LINE) begin
						state_q <= clr_emit_q ? B_OUT : B_IDLE;
					end else begin
						line_q <= line_q + clup_pkg::line_t'(1);
					end
				end
				B_OUT: begin
					if (!res_full) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/cache_line_utilization_profiler_top.sv
// ----------------------------------------------------------------------------
// Cache line utilization profiler
// Lays allocated blocks over a table of cache lines and keeps usage counters.
// ----------------------------------------------------------------------------
// Items enter through push/full and results leave through empty/pop, one
// result per item and in item order. The fields of the oldest result are on
// the result ports while empty is low.
// An add item is worked off by a read-modify-write of the single-port line
// table for each table line that the block spans. A line read reads its
// table entry once, a summary read does not touch the table, and a clear
// item sweeps every one of the 8192 table entries. The back end takes no new
// command until it has handed on the result of the current one.
// A decoded command queue of two entries sits between the front end and the
// back end, and a result queue of two entries sits at the output, so items
// are still taken while the receiver stalls until both queues fill.
// After reset the table is swept to zero, and full stays high during that
// sweep. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module cache_line_utilization_profiler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [15:0] block_offset,
	input  logic [16:0] block_size,
	input  logic [12:0] line_sel,
	output logic        empty,
	input  logic        pop,
	output logic [12:0] line_number,
	output logic [15:0] line_byte_offset,
	output logic [8:0]  used_bytes,
	output logic [8:0]  spare_bytes,
	output logic        line_split,
	output logic        line_active,
	output logic [13:0] arena_lines,
	output logic [13:0] live_lines,
	output logic [13:0] full_lines,
	output logic [15:0] split_blocks,
	output logic [16:0] used_byte_sum,
	output logic        block_was_split
);

	logic [3:0]     line_shift_q;
	logic [16:0]    arena_bytes_q;
	logic           cmd_valid;
	clup_pkg::cmd_t cmd;
	logic           cmd_take;
	logic           init_busy;
	logic           res_wr;
	clup_pkg::res_t res;
	logic           res_full;
	clup_pkg::res_t head;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {15'd0, arena_bytes_q} : {28'd0, line_shift_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_shift_q  <= clup_pkg::SHIFT_DEF;
			arena_bytes_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				arena_bytes_q <= pwdata[16:0];
			end else begin
				line_shift_q <= pwdata[3:0];
			end
		end
	end

	clup_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.block_offset (block_offset),
		.block_size   (block_size),
		.line_sel     (line_sel),
		.line_shift   (line_shift_q),
		.hold         (init_busy),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	clup_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take),
		.arena_bytes (arena_bytes_q),
		.init_busy   (init_busy),
		.res_wr      (res_wr),
		.res         (res),
		.res_full    (res_full)
	);

	clup_res_q u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	assign line_number      = head.line_number;
	assign line_byte_offset = head.line_byte_offset;
	assign used_bytes       = head.used_bytes;
	assign spare_bytes      = head.spare_bytes;
	assign line_split       = head.line_split;
	assign line_active      = head.line_active;
	assign arena_lines      = head.arena_lines;
	assign live_lines       = head.live_lines;
	assign full_lines       = head.full_lines;
	assign split_blocks     = head.split_blocks;
	assign used_byte_sum    = head.used_byte_sum;
	assign block_was_split  = head.block_was_split;

endmodule

FILE: dv/clup_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache line utilization profiler scoreboard
// Keeps a shadow line table, the usage counters and the two registers, works
// out the result of every accepted item and checks the results in order.
// ----------------------------------------------------------------------------
package clup_scoreboard_pkg;

	import clup_pkg::*;

	localparam logic [2:0] LINE_SHIFT_ADDR  = 3'd0;
	localparam logic [2:0] ARENA_BYTES_ADDR = 3'd4;

	localparam int unsigned LINE_COUNT_MAX  = 16383;
	localparam int unsigned SPLIT_COUNT_MAX = 65535;
	localparam int unsigned BYTE_SUM_MAX    = 131071;

	class line_usage_scoreboard;
		bit [8:0]    line_usage [MAX_LINES];
		bit          split_mark [MAX_LINES];
		int unsigned active_count;
		int unsigned full_count;
		int unsigned split_count;
		int unsigned byte_sum;
		bit [3:0]    line_shift = SHIFT_DEF;
		bit [16:0]   arena_bytes;
		res_t        expected_results [$];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned kind_seen [4];

		function void write_register(logic [2:0] addr, logic [31:0] data);
			if (addr == LINE_SHIFT_ADDR) begin
				line_shift = data[3:0];
			end else if (addr == ARENA_BYTES_ADDR) begin
				arena_bytes = data[16:0];
			end
		endfunction

		function int unsigned effective_shift();
			if (line_shift < SHIFT_MIN || line_shift > SHIFT_MAX) begin
				return SHIFT_DEF;
			end
			return line_shift;
		endfunction

		function int unsigned bump(int unsigned value, int unsigned limit);
			return (value < limit) ? value + 1 : limit;
		endfunction

		function void clear_table();
			foreach (line_usage[i]) begin
				line_usage[i] = '0;
				split_mark[i] = 1'b0;
			end
			active_count = 0;
			full_count = 0;
			split_count = 0;
			byte_sum = 0;
		endfunction

		// Lays one block over the table and returns whether it spans several lines.
		function bit add_block(int unsigned off, int unsigned size);
			int unsigned s;
			int unsigned lsz;
			int unsigned end_byte;
			int unsigned start_ln;
			int unsigned end_ln;
			int unsigned last_in_table;
			int unsigned lo;
			int unsigned hi;
			int unsigned old_bytes;
			int unsigned new_bytes;
			bit          split;
			s = effective_shift();
			lsz = 1 << s;
			end_byte = off + size;
			if (size == 0) begin
				return 1'b0;
			end
			start_ln = off >> s;
			end_ln = (end_byte - 1) >> s;
			split = end_ln > start_ln;
			if (split) begin
				split_count = bump(split_count, SPLIT_COUNT_MAX);
			end
			last_in_table = (end_ln < MAX_LINES - 1) ? end_ln : MAX_LINES - 1;
			for (int unsigned ln = start_ln; ln <= last_in_table; ln++) begin
				lo = (off > (ln << s)) ? off : (ln << s);
				hi = (end_byte < ((ln + 1) << s)) ? end_byte : ((ln + 1) << s);
				if (lo >= hi) begin
					continue;
				end
				if (split) begin
					split_mark[ln] = 1'b1;
				end
				old_bytes = line_usage[ln];
				if (old_bytes >= lsz) begin
					continue;
				end
				new_bytes = old_bytes + (hi - lo);
				if (new_bytes > lsz) begin
					new_bytes = lsz;
				end
				line_usage[ln] = 9'(new_bytes);
				if (old_bytes == 0) begin
					active_count = bump(active_count, LINE_COUNT_MAX);
				end
				if (new_bytes == lsz) begin
					full_count = bump(full_count, LINE_COUNT_MAX);
				end
				byte_sum += new_bytes - old_bytes;
				if (byte_sum > BYTE_SUM_MAX) begin
					byte_sum = BYTE_SUM_MAX;
				end
			end
			return split;
		endfunction

		function res_t predict(kind_t k, int unsigned off, int unsigned size,
				int unsigned idx);
			res_t        r;
			int unsigned s;
			int unsigned lsz;
			int unsigned used;
			int unsigned total;
			r = '0;
			s = effective_shift();
			lsz = 1 << s;
			case (k)
				KIND_ADD: begin
					r.block_was_split = add_block(off, size);
				end
				KIND_READ: begin
					used = line_usage[idx];
					if (used > lsz) begin
						used = lsz;
					end
					r.line_number = 13'(idx);
					r.line_byte_offset = 16'(idx << s);
					r.used_bytes = 9'(used);
					r.spare_bytes = 9'(lsz - used);
					r.line_split = split_mark[idx];
					r.line_active = (used != 0);
				end
				KIND_SUM: begin
					if (arena_bytes != 0) begin
						total = (arena_bytes + lsz - 1) >> s;
						if (total > LINE_COUNT_MAX) begin
							total = LINE_COUNT_MAX;
						end
						r.arena_lines = 14'(total);
						r.live_lines = 14'(active_count);
						r.full_lines = 14'(full_count);
						r.split_blocks = 16'(split_count);
						r.used_byte_sum = 17'(byte_sum);
					end
				end
				default: begin
					clear_table();
				end
			endcase
			return r;
		endfunction

		function void note_item(kind_t k, int unsigned off, int unsigned size,
				int unsigned idx);
			res_t r;
			kind_seen[k]++;
			r = predict(k, off, size, idx);
			expected_results.insert(expected_results.size(), r);
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: result with no item waiting, expected none, actual %h",
					$time, got);
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			check_field("line_number", want.line_number, got.line_number);
			check_field("line_byte_offset", want.line_byte_offset, got.line_byte_offset);
			check_field("used_bytes", want.used_bytes, got.used_bytes);
			check_field("spare_bytes", want.spare_bytes, got.spare_bytes);
			check_field("line_split", want.line_split, got.line_split);
			check_field("line_active", want.line_active, got.line_active);
			check_field("arena_lines", want.arena_lines, got.arena_lines);
			check_field("live_lines", want.live_lines, got.live_lines);
			check_field("full_lines", want.full_lines, got.full_lines);
			check_field("split_blocks", want.split_blocks, got.split_blocks);
			check_field("used_byte_sum", want.used_byte_sum, got.used_byte_sum);
			check_field("block_was_split", want.block_was_split, got.block_was_split);
		endfunction
	endclass

endpackage

FILE: dv/cache_line_utilization_profiler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache line utilization profiler testbench
// Drives add, line read, summary and clear items through the queue ports
// under several line sizes and arena sizes, with random idling on both sides,
// and checks every result against a shadow line table kept by the scoreboard.
// ----------------------------------------------------------------------------
module cache_line_utilization_profiler_top_tb;

	import clup_pkg::*;
	import clup_scoreboard_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT   = 100000;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES    = 4;
	localparam int unsigned TAIL_CYCLES      = 20;
	localparam int unsigned RANDOM_PHASES    = 7;
	localparam int unsigned PHASE_ITEMS      = 100;
	localparam int unsigned HOLD_PHASE       = 1;
	localparam int unsigned PAUSE_PHASE      = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  kind = KIND_ADD;
	logic [15:0] block_offset = '0;
	logic [16:0] block_size = '0;
	logic [12:0] line_sel = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [12:0] line_number;
	logic [15:0] line_byte_offset;
	logic [8:0]  used_bytes;
	logic [8:0]  spare_bytes;
	logic        line_split;
	logic        line_active;
	logic [13:0] arena_lines;
	logic [13:0] live_lines;
	logic [13:0] full_lines;
	logic [15:0] split_blocks;
	logic [16:0] used_byte_sum;
	logic        block_was_split;

	res_t        observed;
	bit          idle_enable = 1'b1;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned register_writes = 0;
	int unsigned leftover = 0;
	int unsigned quiet_cycles = 0;

	line_usage_scoreboard sb = new();

	cache_line_utilization_profiler_top dut (.*);

	assign observed = {line_number, line_byte_offset, used_bytes, spare_bytes, line_split,
		line_active, arena_lines, live_lines, full_lines, split_blocks, used_byte_sum,
		block_was_split};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			sb.check_result(observed);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : receiver
		int unsigned stall_left;
		int unsigned holds_served;
		stall_left = 0;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				stall_left = LONG_HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				pop = 1'b0;
				stall_left--;
			end else if (idle_enable && $urandom_range(0, 99) < rx_idle_pct) begin
				pop = 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				pop = 1'b1;
			end
		end
	end

	task automatic send_item(kind_t k, int unsigned off, int unsigned size,
			int unsigned idx);
		kind = k;
		block_offset = 16'(off);
		block_size = 17'(size);
		line_sel = 13'(idx);
		push = 1'b1;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		sb.note_item(k, block_offset, block_size, line_sel);
		@(negedge clk);
		if (idle_enable && $urandom_range(0, 99) < tx_idle_pct) begin
			push = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		push = 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		sb.write_register(addr, data);
		register_writes++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
	endtask

	task automatic set_registers(logic [31:0] shift_word, logic [31:0] arena_word);
		drain_results();
		write_reg(LINE_SHIFT_ADDR, shift_word);
		write_reg(ARENA_BYTES_ADDR, arena_word);
	endtask

	task automatic run_directed();
		send_item(KIND_SUM, 0, 0, 0);
		send_item(KIND_ADD, 0, 0, 0);
		send_item(KIND_ADD, 0, 64, 0);
		send_item(KIND_ADD, 60, 10, 0);
		send_item(KIND_READ, 0, 0, 0);
		send_item(KIND_READ, 0, 0, 1);
		send_item(KIND_READ, 0, 0, 8191);
		send_item(KIND_ADD, 65535, 131071, 0);
		set_registers(8, 65536);
		send_item(KIND_SUM, 0, 0, 0);
		send_item(KIND_ADD, 0, 65536, 0);
		send_item(KIND_ADD, 65535, 131071, 0);
		send_item(KIND_SUM, 0, 0, 0);
		// A smaller line size over the old records: reads clamp, adds leave them.
		set_registers(3, 65536);
		send_item(KIND_READ, 0, 0, 0);
		send_item(KIND_ADD, 0, 4, 0);
		send_item(KIND_SUM, 0, 0, 0);
		send_item(KIND_CLEAR, 0, 0, 0);
		send_item(KIND_ADD, 65535, 131071, 0);
		send_item(KIND_READ, 0, 0, 8191);
		send_item(KIND_SUM, 0, 0, 0);
		set_registers(15, 131071);
		send_item(KIND_SUM, 0, 0, 0);
		send_item(KIND_READ, 0, 0, 5);
		set_registers(0, 131071);
		send_item(KIND_ADD, 100, 300, 0);
		send_item(KIND_READ, 0, 0, 2);
		send_item(KIND_CLEAR, 0, 0, 0);
		send_item(KIND_SUM, 0, 0, 0);
	endtask

	// Adds stay mostly in the low 2 KB so that lines overlap and fill up.
	task automatic send_random_item();
		int unsigned pick;
		int unsigned s;
		int unsigned lsz;
		int unsigned off;
		int unsigned size;
		int unsigned idx;
		kind_t       k;
		s = sb.effective_shift();
		lsz = 1 << s;
		off = $urandom_range(0, 65535);
		size = $urandom_range(0, 131071);
		idx = $urandom_range(0, 8191);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			k = KIND_ADD;
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				size = $urandom_range(0, 131071);
			end else if (pick < 8) begin
				size = $urandom_range(0, 4 * lsz);
			end else if (pick < 12) begin
				off = $urandom_range(0, 2047);
				size = 0;
			end else if (pick < 40) begin
				off = $urandom_range(0, 2047) & ~(lsz - 1);
				size = lsz * $urandom_range(1, 3);
			end else begin
				off = $urandom_range(0, 2047);
				size = $urandom_range(1, 3 * lsz);
			end
		end else if (pick < 80) begin
			k = KIND_READ;
			if ($urandom_range(0, 9) < 7) begin
				idx = $urandom_range(0, (2048 >> s) + 1);
			end
		end else if (pick < 99) begin
			k = KIND_SUM;
		end else begin
			k = KIND_CLEAR;
		end
		send_item(k, off, size, idx);
	endtask

	task automatic run_random_phase(int unsigned phase);
		int unsigned saved_pct;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (phase == HOLD_PHASE && i == PHASE_ITEMS / 2) begin
				saved_pct = tx_idle_pct;
				tx_idle_pct = 0;
				hold_requests++;
				for (int j = 0; j < 12; j++) begin
					send_item(KIND_READ, $urandom_range(0, 65535), $urandom_range(0, 131071),
						$urandom_range(0, 40));
				end
				tx_idle_pct = saved_pct;
			end
			if (phase == PAUSE_PHASE && i == PHASE_ITEMS / 2) begin
				drain_results();
			end
			send_random_item();
		end
	endtask

	initial begin : stimulus
		int unsigned shift_val;
		int unsigned arena_val;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					shift_val = 3;
					arena_val = 131071;
				end
				1: begin
					shift_val = 8;
					arena_val = 0;
				end
				2: begin
					shift_val = 5;
					arena_val = $urandom_range(1, 65536);
				end
				3: begin
					shift_val = 9;
					arena_val = 65536;
				end
				4: begin
					shift_val = 4;
					arena_val = $urandom_range(1, 65536);
				end
				5: begin
					shift_val = 7;
					arena_val = 1;
				end
				default: begin
					shift_val = 6;
					arena_val = $urandom_range(1, 65536);
				end
			endcase
			set_registers(($urandom & 32'hFFFF_FFF0) | shift_val,
				($urandom & 32'hFFFE_0000) | arena_val);
			idle_enable = (p != RANDOM_PHASES - 1);
			tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
			rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
			if (p == 0 || $urandom_range(0, 1) == 1) begin
				send_item(KIND_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 131071),
					$urandom_range(0, 8191));
			end
			run_random_phase(p);
		end
		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		leftover = sb.pending();
		if (leftover != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time, leftover);
		end
		$display("Ran %0d add, %0d line read, %0d summary and %0d clear items over %0d %s",
			sb.kind_seen[KIND_ADD], sb.kind_seen[KIND_READ], sb.kind_seen[KIND_SUM],
			sb.kind_seen[KIND_CLEAR], register_writes, "register writes.");
		$display("Compared %0d results with the shadow line table, %0d mismatching fields.",
			sb.results_checked, sb.mismatches);
		if (sb.mismatches == 0 && leftover == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/clup_pkg.sv
hw/rtl/clup_front.sv
hw/rtl/clup_res_q.sv
hw/rtl/clup_back.sv
hw/rtl/cache_line_utilization_profiler_top.sv
dv/clup_scoreboard_pkg.sv
dv/cache_line_utilization_profiler_top_tb.sv
